@@ design/ctps_pkg.sv @@
// Shared types and constants for the countdown task pool scheduler.
// Used by ctps_wait_q, ctps_ready_list and countdown_task_pool_scheduler.
package ctps_pkg;

	localparam int DEF_MAX_READY  = 16;
	localparam int DEF_WAIT_DEPTH = 32;
	localparam int ID_W           = 16;
	localparam int TIME_W         = 16;
	localparam int ENTRY_W        = ID_W + TIME_W;
	localparam int LIMIT_W        = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);

	typedef enum logic [1:0] {
		REQ_SUBMIT = 2'd0,
		REQ_ADMIT  = 2'd1,
		REQ_TICK   = 2'd2
	} req_e_t;

	typedef enum logic [2:0] {
		STS_QUEUED     = 3'd0,
		STS_WAIT_FULL  = 3'd1,
		STS_ADMITTED   = 3'd2,
		STS_READY_FULL = 3'd3,
		STS_WAIT_EMPTY = 3'd4,
		STS_RETIRED    = 3'd5,
		STS_TICK_NONE  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADMIT_WR,
		ST_TICK,
		ST_EMIT
	} state_t;

	// wait queue control and status
	typedef struct packed {
		logic push;
		logic rd;
		logic pop;
	} wq_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wq_sts_t;

endpackage

@@ design/countdown_task_pool_scheduler.sv @@
// Countdown task pool scheduler, top level: request sequencer, output register.
// Depends on ctps_pkg, ctps_wait_q and ctps_ready_list.
//
// One item at a time. A submit goes through the emit state; an admit does a
// registered wait queue read, then the ready list write, then the emit
// (straight to the emit when refused). In a tick, one ready slot per cycle
// passes through the single decrement/compare unit, unless a retirement
// waits on a stalled output register, and is either kept (compacted in
// place) or retired; a closing step and an emit step follow. Retirements go
// out through a one-deep output register; downstream stall holds the tick
// walk. in_stall is low only in the idle state; the output register may
// still hold a result then. The core_limit register (zero writes ignored)
// caps the ready list, never above MAX_READY. No clearing pass after reset.
module countdown_task_pool_scheduler #(
	parameter int MAX_READY  = ctps_pkg::DEF_MAX_READY,
	parameter int WAIT_DEPTH = ctps_pkg::DEF_WAIT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic [ctps_pkg::TIME_W-1:0]  exec_time,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [ctps_pkg::ID_W-1:0]    task_id,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ctps_pkg::LIMIT_W-1:0] core_limit
);

	localparam int CNT_W = $clog2(MAX_READY + 1);
	localparam int IDX_W = (MAX_READY > 1) ? $clog2(MAX_READY) : 1;
	localparam int IW    = ctps_pkg::ID_W;
	localparam int TW    = ctps_pkg::TIME_W;

	ctps_pkg::state_t  state_q, state_d;
	ctps_pkg::status_t res_status_q, res_status_d;
	ctps_pkg::status_t out_status_q, out_status_d;
	logic [IW-1:0]     res_id_q, res_id_d;
	logic [IW-1:0]     out_id_q, out_id_d;
	logic              out_valid_q, out_last_q, out_last_d, out_load, out_free;
	logic [IW-1:0]     next_id_q, next_id_d;
	logic [CNT_W-1:0]  ready_cnt_q, ready_cnt_d;
	logic [CNT_W-1:0]  idx_q, idx_d, keep_q, keep_d;
	logic              pend_q, pend_d;
	logic [IW-1:0]     pend_id_q, pend_id_d;
	logic [ctps_pkg::LIMIT_W-1:0] limit_q;
	logic              ready_full;

	ctps_pkg::wq_ctl_t wq_ctl;
	ctps_pkg::wq_sts_t wq_sts;
	logic [ctps_pkg::ENTRY_W-1:0] wq_push_data, wq_rd_data;

	logic             rl_we, rl_retire;
	logic [IDX_W-1:0] rl_waddr;
	logic [IW-1:0]    rl_wid, rl_rd_id;
	logic [TW-1:0]    rl_wrem, rl_dec;

	ctps_wait_q #(.WAIT_DEPTH(WAIT_DEPTH)) u_wait_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (wq_ctl),
		.push_data (wq_push_data),
		.rd_data   (wq_rd_data),
		.sts       (wq_sts)
	);

	ctps_ready_list #(.MAX_READY(MAX_READY)) u_ready_list (
		.clk       (clk),
		.we        (rl_we),
		.waddr     (rl_waddr),
		.wid       (rl_wid),
		.wrem      (rl_wrem),
		.raddr     (idx_q[IDX_W-1:0]),
		.rd_id     (rl_rd_id),
		.rd_dec    (rl_dec),
		.rd_retire (rl_retire)
	);

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ctps_pkg::ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign ready_full = (32'(ready_cnt_q) >= 32'(limit_q))
		|| (ready_cnt_q == CNT_W'(MAX_READY));
	assign wq_push_data = {next_id_q + IW'(1), exec_time};

	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		next_id_d    = next_id_q;
		ready_cnt_d  = ready_cnt_q;
		idx_d        = idx_q;
		keep_d       = keep_q;
		pend_d       = pend_q;
		pend_id_d    = pend_id_q;
		wq_ctl       = '0;
		rl_we        = 1'b0;
		rl_waddr     = keep_q[IDX_W-1:0];
		rl_wid       = rl_rd_id;
		rl_wrem      = rl_dec;
		out_load     = 1'b0;
		out_status_d = res_status_q;
		out_id_d     = res_id_q;
		out_last_d   = 1'b1;

		unique case (state_q)
			ctps_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						ctps_pkg::REQ_SUBMIT: begin
							state_d = ctps_pkg::ST_EMIT;
							if (wq_sts.full) begin
								res_status_d = ctps_pkg::STS_WAIT_FULL;
								res_id_d     = '0;
							end else begin
								wq_ctl.push  = 1'b1;
								next_id_d    = next_id_q + IW'(1);
								res_status_d = ctps_pkg::STS_QUEUED;
								res_id_d     = next_id_q + IW'(1);
							end
						end
						ctps_pkg::REQ_ADMIT: begin
							res_id_d = '0;
							if (wq_sts.empty) begin
								res_status_d = ctps_pkg::STS_WAIT_EMPTY;
								state_d      = ctps_pkg::ST_EMIT;
							end else if (ready_full) begin
								res_status_d = ctps_pkg::STS_READY_FULL;
								state_d      = ctps_pkg::ST_EMIT;
							end else begin
								wq_ctl.rd = 1'b1;
								state_d   = ctps_pkg::ST_ADMIT_WR;
							end
						end
						ctps_pkg::REQ_TICK: begin
							idx_d   = '0;
							keep_d  = '0;
							pend_d  = 1'b0;
							state_d = ctps_pkg::ST_TICK;
						end
						default: ;
					endcase
				end
			end
			ctps_pkg::ST_ADMIT_WR: begin
				rl_we        = 1'b1;
				rl_waddr     = ready_cnt_q[IDX_W-1:0];
				rl_wid       = wq_rd_data[ctps_pkg::ENTRY_W-1:TW];
				rl_wrem      = wq_rd_data[TW-1:0];
				wq_ctl.pop   = 1'b1;
				ready_cnt_d  = ready_cnt_q + CNT_W'(1);
				res_status_d = ctps_pkg::STS_ADMITTED;
				res_id_d     = wq_rd_data[ctps_pkg::ENTRY_W-1:TW];
				state_d      = ctps_pkg::ST_EMIT;
			end
			ctps_pkg::ST_TICK: begin
				if (idx_q == ready_cnt_q) begin
					ready_cnt_d  = keep_q;
					pend_d       = 1'b0;
					res_status_d = pend_q ? ctps_pkg::STS_RETIRED : ctps_pkg::STS_TICK_NONE;
					res_id_d     = pend_q ? pend_id_q : '0;
					state_d      = ctps_pkg::ST_EMIT;
				end else if (rl_retire) begin
					// hold one retirement back so the final one can carry last
					if (!pend_q) begin
						pend_d    = 1'b1;
						pend_id_d = rl_rd_id;
						idx_d     = idx_q + CNT_W'(1);
					end else if (out_free) begin
						out_load     = 1'b1;
						out_status_d = ctps_pkg::STS_RETIRED;
						out_id_d     = pend_id_q;
						out_last_d   = 1'b0;
						pend_id_d    = rl_rd_id;
						idx_d        = idx_q + CNT_W'(1);
					end
				end else begin
					rl_we  = 1'b1;
					keep_d = keep_q + CNT_W'(1);
					idx_d  = idx_q + CNT_W'(1);
				end
			end
			ctps_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ctps_pkg::ST_IDLE;
				end
			end
			default: state_d = ctps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctps_pkg::ST_IDLE;
			next_id_q   <= '0;
			ready_cnt_q <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			limit_q     <= ctps_pkg::LIMIT_RST;
		end else begin
			state_q     <= state_d;
			next_id_q   <= next_id_d;
			ready_cnt_q <= ready_cnt_d;
			pend_q      <= pend_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && core_limit != '0)
				limit_q <= core_limit;
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		idx_q        <= idx_d;
		keep_q       <= keep_d;
		pend_id_q    <= pend_id_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_id_q     <= out_id_d;
			out_last_q   <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign task_id   = out_id_q;
	assign last      = out_last_q;

	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_cnt_q <= CNT_W'(MAX_READY))
		else $error("ready count above MAX_READY");

	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == ctps_pkg::ST_TICK)
		else $error("held retirement outside a tick");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctps_pkg::ST_TICK |-> keep_q <= idx_q && idx_q <= ready_cnt_q)
		else $error("tick walk indexes out of order");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		wq_ctl.push |-> !wq_sts.full)
		else $error("push into full wait queue");

endmodule

@@ design/ctps_wait_q.sv @@
// FIFO wait queue of submitted tasks: {id, time} entries in a memory
// with a registered head read. Depends on ctps_pkg.
module ctps_wait_q #(
	parameter int WAIT_DEPTH = ctps_pkg::DEF_WAIT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctps_pkg::wq_ctl_t            ctl,
	input  logic [ctps_pkg::ENTRY_W-1:0] push_data,
	output logic [ctps_pkg::ENTRY_W-1:0] rd_data,
	output ctps_pkg::wq_sts_t            sts
);

	localparam int PW  = $clog2(WAIT_DEPTH);
	localparam int CW  = $clog2(WAIT_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(WAIT_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(WAIT_DEPTH);

	logic [ctps_pkg::ENTRY_W-1:0] mem [WAIT_DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.push)
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + PW'(1);
			if (ctl.pop)
				head_q <= (head_q == LAST_PTR) ? '0 : head_q + PW'(1);
			if (ctl.push && !ctl.pop)
				cnt_q <= cnt_q + CW'(1);
			else if (ctl.pop && !ctl.push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[tail_q] <= push_data;
		if (ctl.rd)
			rd_data <= mem[head_q];
	end

	assign sts.full  = (cnt_q == FULL_CNT);
	assign sts.empty = (cnt_q == '0);

endmodule

@@ design/ctps_ready_list.sv @@
// Ready list storage (id, ticks left per slot) and shared decrement/compare
// unit, walked one slot a cycle unless stalled. Depends on ctps_pkg.
module ctps_ready_list #(
	parameter int MAX_READY = ctps_pkg::DEF_MAX_READY,
	localparam int IDX_W = (MAX_READY > 1) ? $clog2(MAX_READY) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [ctps_pkg::ID_W-1:0]   wid,
	input  logic [ctps_pkg::TIME_W-1:0] wrem,
	input  logic [IDX_W-1:0]            raddr,
	output logic [ctps_pkg::ID_W-1:0]   rd_id,
	output logic [ctps_pkg::TIME_W-1:0] rd_dec,
	output logic                        rd_retire
);

	logic [ctps_pkg::ID_W-1:0]   ids_q [MAX_READY];
	logic [ctps_pkg::TIME_W-1:0] rem_q [MAX_READY];
	logic [ctps_pkg::TIME_W-1:0] rem;

	always_ff @(posedge clk) begin
		if (we) begin
			ids_q[waddr] <= wid;
			rem_q[waddr] <= wrem;
		end
	end

	assign rem       = rem_q[raddr];
	assign rd_id     = ids_q[raddr];
	assign rd_dec    = rem - ctps_pkg::TIME_W'(1);
	// a count of 0 or 1 reaches zero or below on this tick
	assign rd_retire = (rem <= ctps_pkg::TIME_W'(1));

endmodule
